// File: rtl/rsv_pkg.sv
// Shared types, constants and helpers for the redundant sector vote block.
// No dependencies; used by every module of the block.
package rsv_pkg;

  localparam int MAX_SRC = 8;

  localparam logic [7:0] FILL_ZERO  = 8'h00;
  localparam logic [7:0] FILL_SPACE = 8'h20;
  localparam logic [7:0] FILL_ONES  = 8'hFF;

  localparam logic CFG_ADDR_THRESH = 1'b0;

  typedef enum logic [2:0] {
    ORG_UNANIMOUS   = 3'd0,
    ORG_MAJORITY    = 3'd1,
    ORG_SPLIT       = 3'd2,
    ORG_CONSENSUS   = 3'd3,
    ORG_UNRECOVERED = 3'd4
  } origin_t;

  // whole-sector summary from lanes and masks to the merge pipeline
  typedef struct packed {
    logic [MAX_SRC-1:0][MAX_SRC-1:0] eq;
    logic [MAX_SRC-1:0]              fill;
    logic [MAX_SRC-1:0]              present;
    logic [MAX_SRC-1:0]              good;
  } summary_t;

  typedef struct packed {
    logic       sole_good;
    logic [3:0] agreement;
    origin_t    origin;
    logic [2:0] chosen_source;
    logic       has_source;
  } verdict_t;

  function automatic logic [3:0] popcount8(input logic [7:0] m);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, m[i]};
    end
    return n;
  endfunction

  function automatic logic is_fill_byte(input logic [7:0] v);
    return (v == FILL_ZERO) || (v == FILL_SPACE) || (v == FILL_ONES);
  endfunction

endpackage

// File: rtl/redundant_sector_vote.sv
// Redundant sector vote, top level: per-source lanes, mask latch, config register, merge.
// Depends on rsv_pkg, rsv_lane and rsv_merge.
//
// Takes one byte position of all source copies per beat, one beat every cycle,
// with no gap needed between sectors. The verdict for a sector leaves on the
// out channel after passing the three register stages of the merge pipeline
// (snapshot, agreement counts, verdict). Input keeps flowing while a verdict
// waits; it stalls only once all three merge stages hold verdicts that are not
// taken. Masks are sampled on a sector's first beat; source bits at or above
// SOURCES are ignored. The threshold register sits at address 0 and should be
// written only while idle.
module redundant_sector_vote #(
  parameter int SOURCES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // present_mask[7:0], good_mask[15:8], source_bytes[79:16]
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // has_source[0], chosen_source[3:1], origin[6:4], agreement[10:7], sole_good[11], zero[15:12]
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int N = rsv_pkg::MAX_SRC;
  localparam logic [N-1:0] SRC_MASK = N'((1 << SOURCES) - 1);

  logic              beat;
  logic              first;
  logic              inside_r;
  logic [N-1:0]      present_r, good_r, present_nxt, good_nxt;
  logic [3:0]        thresh_r;
  logic [N-1:0][N-1:0] eq_rows;
  logic [N-1:0]      fill_bits;
  rsv_pkg::summary_t summary;
  rsv_pkg::verdict_t verdict;
  logic              take_ready;

  assign in_tready = take_ready;
  assign beat      = in_tvalid && in_tready;
  assign first     = !inside_r;

  assign present_nxt = first ? (in_tdata[7:0] & SRC_MASK) : present_r;
  assign good_nxt    = first ? (in_tdata[15:8] & in_tdata[7:0] & SRC_MASK) : good_r;

  genvar a;
  generate
    for (a = 0; a < N; a++) begin : g_lane
      if (a < SOURCES) begin : g_on
        rsv_lane #(
          .SOURCES(SOURCES),
          .LANE   (a)
        ) u_lane (
          .clk       (clk),
          .rst_n     (rst_n),
          .beat      (beat),
          .first     (first),
          .bytes     (in_tdata[79:16]),
          .eq_row_nxt(eq_rows[a]),
          .fill_nxt  (fill_bits[a])
        );
      end else begin : g_off
        assign eq_rows[a]   = '0;
        assign fill_bits[a] = 1'b0;
      end
    end
  endgenerate

  assign summary.eq      = eq_rows;
  assign summary.fill    = fill_bits;
  assign summary.present = present_nxt;
  assign summary.good    = good_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r  <= 1'b0;
      present_r <= '0;
      good_r    <= '0;
      thresh_r  <= 4'd0;
    end else begin
      if (beat) begin
        inside_r  <= !in_tlast;
        present_r <= present_nxt;
        good_r    <= good_nxt;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && cfg_paddr[2] == rsv_pkg::CFG_ADDR_THRESH) begin
        thresh_r <= cfg_pwdata[3:0];
      end
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == rsv_pkg::CFG_ADDR_THRESH) ? {28'd0, thresh_r} : 32'd0;

  rsv_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (beat && in_tlast),
    .summary   (summary),
    .threshold (thresh_r),
    .take_ready(take_ready),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (verdict)
  );

  assign out_tdata = {4'd0, verdict};

endmodule

// File: rtl/rsv_lane.sv
// One source lane: first byte, uniformity and equality against every other source.
// Depends on rsv_pkg.
module rsv_lane #(
  parameter int SOURCES = 8,
  parameter int LANE    = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        beat,
  input  logic                        first,
  input  logic [8*rsv_pkg::MAX_SRC-1:0] bytes,
  output logic [rsv_pkg::MAX_SRC-1:0] eq_row_nxt,
  output logic                        fill_nxt
);

  logic [7:0]                  first_val_r, first_val_nxt;
  logic                        uniform_r, uniform_nxt;
  logic [rsv_pkg::MAX_SRC-1:0] eq_r;
  logic [7:0]                  cur;

  assign cur           = bytes[8*LANE +: 8];
  assign first_val_nxt = first ? cur : first_val_r;
  assign uniform_nxt   = (first ? 1'b1 : uniform_r) & (cur == first_val_nxt);
  assign fill_nxt      = uniform_nxt & rsv_pkg::is_fill_byte(first_val_nxt);

  always_comb begin
    for (int j = 0; j < rsv_pkg::MAX_SRC; j++) begin
      if (j == LANE) begin
        eq_row_nxt[j] = 1'b1;
      end else if (j < SOURCES) begin
        eq_row_nxt[j] = (first ? 1'b1 : eq_r[j]) & (cur == bytes[8*j +: 8]);
      end else begin
        eq_row_nxt[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_val_r <= '0;
      uniform_r   <= 1'b1;
      eq_r        <= '1;
    end else if (beat) begin
      first_val_r <= first_val_nxt;
      uniform_r   <= uniform_nxt;
      eq_r        <= eq_row_nxt;
    end
  end

endmodule

// File: rtl/rsv_merge.sv
// Merge pipeline: snapshot, agreement counts, then verdict into the output register.
// Depends on rsv_pkg.
module rsv_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rsv_pkg::summary_t   summary,
  input  logic [3:0]          threshold,
  output logic                take_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output rsv_pkg::verdict_t   res
);

  localparam int N = rsv_pkg::MAX_SRC;

  logic rdy1, rdy2, rdy3;
  logic v1_r, v2_r, v3_r;

  rsv_pkg::summary_t s1_r;

  logic [N-1:0][3:0] cg_nxt, cp_nxt, cg_r, cp_r;
  logic [3:0]        g_r, p_r;
  logic [N-1:0]      fill2_r;
  logic [2:0]        fb_nxt, fb_r;

  rsv_pkg::verdict_t res_r, res_nxt;

  assign rdy3       = !v3_r || res_ready;
  assign rdy2       = !v2_r || rdy3;
  assign rdy1       = !v1_r || rdy2;
  assign take_ready = rdy1;
  assign res_valid  = v3_r;
  assign res        = res_r;

  // match counts per copy in each mask; fallback: lowest present, non-fill first
  always_comb begin
    fb_nxt = 3'd0;
    for (int i = 0; i < N; i++) begin
      cg_nxt[i] = s1_r.good[i]    ? rsv_pkg::popcount8(s1_r.good & s1_r.eq[i])    : 4'd0;
      cp_nxt[i] = s1_r.present[i] ? rsv_pkg::popcount8(s1_r.present & s1_r.eq[i]) : 4'd0;
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (s1_r.present[i]) fb_nxt = 3'(i);
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (s1_r.present[i] && !s1_r.fill[i]) fb_nxt = 3'(i);
    end
  end

  // verdict
  always_comb begin
    logic [3:0] ag, ap;
    logic [2:0] bg, bp;
    ag = 4'd0;
    ap = 4'd0;
    bg = 3'd0;
    bp = 3'd0;
    for (int i = 0; i < N; i++) begin
      if (cg_r[i] > ag) begin
        ag = cg_r[i];
        bg = 3'(i);
      end
      if (cp_r[i] > ap) begin
        ap = cp_r[i];
        bp = 3'(i);
      end
    end
    res_nxt.has_source    = (p_r != 4'd0);
    res_nxt.sole_good     = (g_r == 4'd1);
    res_nxt.origin        = rsv_pkg::ORG_UNRECOVERED;
    res_nxt.chosen_source = fb_r;
    res_nxt.agreement     = 4'd0;
    if (g_r != 4'd0) begin
      res_nxt.chosen_source = bg;
      res_nxt.agreement     = ag;
      if (ag == g_r) begin
        res_nxt.origin = rsv_pkg::ORG_UNANIMOUS;
      end else if ({ag, 1'b0} > {1'b0, g_r}) begin
        res_nxt.origin = rsv_pkg::ORG_MAJORITY;
      end else begin
        res_nxt.origin = rsv_pkg::ORG_SPLIT;
      end
    end else if (threshold != 4'd0 && p_r >= threshold && ap >= threshold
                 && !fill2_r[bp]) begin
      res_nxt.origin        = rsv_pkg::ORG_CONSENSUS;
      res_nxt.chosen_source = bp;
      res_nxt.agreement     = ap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= push;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && push) begin
      s1_r <= summary;
    end
    if (rdy2 && v1_r) begin
      cg_r    <= cg_nxt;
      cp_r    <= cp_nxt;
      g_r     <= rsv_pkg::popcount8(s1_r.good);
      p_r     <= rsv_pkg::popcount8(s1_r.present);
      fill2_r <= s1_r.fill;
      fb_r    <= fb_nxt;
    end
    if (rdy3 && v2_r) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: rtl/rsv_checker.sv
// Port-level checks on the redundant sector vote, bound to the top level.
// Depends on rsv_pkg and redundant_sector_vote.
module rsv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out beat changed while stalled");

  a_no_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |->
      out_tdata[6:4] == rsv_pkg::ORG_UNRECOVERED && out_tdata[10:7] == 4'd0
      && out_tdata[3:1] == 3'd0 && !out_tdata[11])
    else $error("verdict without source is not a plain unrecovered");

  a_unrec_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6:4] == rsv_pkg::ORG_UNRECOVERED |-> out_tdata[10:7] == 4'd0)
    else $error("unrecovered verdict carries agreement");

  a_sole_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |->
      out_tdata[6:4] == rsv_pkg::ORG_UNANIMOUS && out_tdata[10:7] == 4'd1 && out_tdata[0])
    else $error("single good copy must be a unanimous verdict of one");

endmodule

bind redundant_sector_vote rsv_checker u_rsv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// File: dv/rsv_vote_checker.sv
// Checker for the redundant sector vote: watches the in, out and cfg ports,
// predicts one verdict per sector and compares it field by field.
// Depends on rsv_pkg for the verdict layout, origin codes and fill bytes.
module rsv_vote_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          verdicts_waiting,
  output int          verdicts_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] THRESH_ADDR = {rsv_pkg::CFG_ADDR_THRESH, 2'b00};

  rsv_pkg::verdict_t pending_verdicts[$];
  logic [7:0] same_copy [rsv_pkg::MAX_SRC];   // bit b of row a: sources a and b matched on every beat
  logic [7:0] lead_byte [rsv_pkg::MAX_SRC];
  logic [7:0] flat_mask;
  logic [7:0] sector_present;
  logic [7:0] sector_good;
  logic       mid_sector;
  logic [3:0] vote_thresh;

  function automatic bit copies_match(int a, int b);
    return (a == b) ? 1'b1 : same_copy[a][b];
  endfunction

  function automatic bit fill_copy(int s);
    return flat_mask[s] && (lead_byte[s] == rsv_pkg::FILL_ZERO ||
                            lead_byte[s] == rsv_pkg::FILL_SPACE ||
                            lead_byte[s] == rsv_pkg::FILL_ONES);
  endfunction

  // most widely held content in pool; ties go to the lowest source
  function automatic int plurality(logic [7:0] pool, output int agree);
    int pick;
    int tally;
    pick = 0;
    agree = 0;
    for (int i = 0; i < rsv_pkg::MAX_SRC; i++) begin
      if (pool[i]) begin
        tally = 0;
        for (int j = 0; j < rsv_pkg::MAX_SRC; j++) begin
          if (pool[j] && copies_match(i, j)) tally++;
        end
        if (tally > agree) begin
          agree = tally;
          pick = i;
        end
      end
    end
    return pick;
  endfunction

  function automatic rsv_pkg::verdict_t sector_verdict();
    rsv_pkg::verdict_t v;
    int n_good;
    int n_present;
    int agree;
    int cand;
    bit got;
    n_good = $countones(sector_good);
    n_present = $countones(sector_present);
    v.has_source = (n_present > 0);
    v.chosen_source = '0;
    v.origin = rsv_pkg::ORG_UNRECOVERED;
    v.agreement = '0;
    v.sole_good = (n_good == 1);
    if (n_good > 0) begin
      cand = plurality(sector_good, agree);
      v.chosen_source = 3'(cand);
      v.agreement = 4'(agree);
      if (agree == n_good) v.origin = rsv_pkg::ORG_UNANIMOUS;
      else if (2 * agree > n_good) v.origin = rsv_pkg::ORG_MAJORITY;
      else v.origin = rsv_pkg::ORG_SPLIT;
    end else if (vote_thresh != 0 && n_present >= vote_thresh) begin
      cand = plurality(sector_present, agree);
      if (agree >= vote_thresh && !fill_copy(cand)) begin
        v.origin = rsv_pkg::ORG_CONSENSUS;
        v.chosen_source = 3'(cand);
        v.agreement = 4'(agree);
      end
    end
    if (v.origin == rsv_pkg::ORG_UNRECOVERED) begin
      got = 1'b0;
      v.agreement = '0;
      v.chosen_source = '0;
      for (int s = 0; s < rsv_pkg::MAX_SRC; s++) begin
        if (!got && sector_present[s] && !fill_copy(s)) begin
          v.chosen_source = 3'(s);
          got = 1'b1;
        end
      end
      for (int s = 0; s < rsv_pkg::MAX_SRC; s++) begin
        if (!got && sector_present[s]) begin
          v.chosen_source = 3'(s);
          got = 1'b1;
        end
      end
    end
    return v;
  endfunction

  task automatic report_field(string what, int want, int seen);
    if (want != seen) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
    end
  endtask

  always @(posedge clk) begin
    rsv_pkg::verdict_t want;
    rsv_pkg::verdict_t seen;
    logic [7:0] lane [rsv_pkg::MAX_SRC];
    if (!rst_n) begin
      mid_sector = 1'b0;
      vote_thresh = '0;
      pending_verdicts.delete();
      fail_count = 0;
      verdicts_checked = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == THRESH_ADDR)
        vote_thresh = cfg_pwdata[3:0];

      if (in_tvalid && in_tready) begin
        for (int s = 0; s < rsv_pkg::MAX_SRC; s++) lane[s] = in_tdata[16 + 8 * s +: 8];
        if (!mid_sector) begin
          sector_present = in_tdata[7:0];
          sector_good = in_tdata[15:8] & in_tdata[7:0];
          flat_mask = '1;
          for (int s = 0; s < rsv_pkg::MAX_SRC; s++) begin
            same_copy[s] = '1;
            lead_byte[s] = lane[s];
          end
        end
        for (int a = 0; a < rsv_pkg::MAX_SRC; a++) begin
          if (lane[a] != lead_byte[a]) flat_mask[a] = 1'b0;
          for (int b = 0; b < rsv_pkg::MAX_SRC; b++) begin
            if (lane[a] != lane[b]) same_copy[a][b] = 1'b0;
          end
        end
        if (in_tlast) begin
          mid_sector = 1'b0;
          pending_verdicts.insert(pending_verdicts.size(), sector_verdict());
        end else begin
          mid_sector = 1'b1;
        end
      end

      if (out_tvalid && out_tready) begin
        seen = out_tdata[11:0];
        if (pending_verdicts.size() == 0) begin
          fail_count++;
          $display("%0t: verdict beat, expected none, got %h", $time, out_tdata);
        end else begin
          want = pending_verdicts.pop_front();
          verdicts_checked++;
          report_field("has_source", want.has_source, seen.has_source);
          report_field("chosen_source", want.chosen_source, seen.chosen_source);
          report_field("origin", want.origin, seen.origin);
          report_field("agreement", want.agreement, seen.agreement);
          report_field("sole_good", want.sole_good, seen.sole_good);
          report_field("pad bits", 0, out_tdata[15:12]);
        end
      end
    end
    verdicts_waiting = pending_verdicts.size();
  end

endmodule

// File: dv/redundant_sector_vote_tb.sv
// Testbench top for redundant_sector_vote: clock, reset, sector stimulus with
// random idling and back-pressure, threshold writes over APB, and the verdict.
// Depends on rsv_pkg, the RTL and rsv_vote_checker.
module redundant_sector_vote_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] THRESH_ADDR = {rsv_pkg::CFG_ADDR_THRESH, 2'b00};
  localparam int HOLD_LEN    = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASES      = 15;
  localparam int PHASE_BEATS = 110;
  localparam int QUIET_PHASE = 2;
  localparam int PRESS_PHASE = 4;

  typedef enum int {PAT_FILL, PAT_FLAT, PAT_NOISE} pattern_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // present_mask[7:0], good_mask[15:8], source_bytes[79:16]
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  // has_source[0], chosen_source[3:1], origin[6:4], agreement[10:7], sole_good[11]
  logic [15:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int verdicts_waiting;
  int verdicts_checked;

  bit steady;
  bit hold_req;
  int beats_sent;
  int sectors_sent;
  int settings_used;
  int idle_cycles;
  int thr_plan [12] = '{2, 3, 1, 8, 5, 4, 6, 7, 9, 15, 0, 3};

  redundant_sector_vote dut (.*);

  rsv_vote_checker vote_check (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .verdicts_waiting, .verdicts_checked
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // verdict receiver
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 19);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_beat(logic [7:0] pm, logic [7:0] gm, logic [63:0] bytes, bit last);
    while (!steady && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      in_tdata <= {16'($urandom), $urandom, $urandom};
      in_tlast <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {bytes, gm, pm};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    beats_sent++;
    if (last) sectors_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (verdicts_waiting != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_threshold(logic [3:0] thr);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= THRESH_ADDR;
    cfg_pwdata <= {28'd0, thr};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    settings_used++;
  endtask

  // copies draw on a few shared contents, with rare one-byte damage or whole-sector noise
  task automatic send_sector(int len);
    logic [7:0]  pmask;
    logic [7:0]  gmask;
    logic [7:0]  fixed [rsv_pkg::MAX_SRC];
    logic [7:0]  cval [rsv_pkg::MAX_SRC];
    pattern_t    style [rsv_pkg::MAX_SRC];
    int          cls [rsv_pkg::MAX_SRC];
    int          kinds;
    int          bad_src;
    int          bad_pos;
    int          r;
    bit          noisy;
    logic [7:0]  v;
    logic [63:0] word;
    r = $urandom_range(99);
    pmask = (r < 8) ? 8'h00 : (r < 30) ? 8'hFF : 8'($urandom);
    r = $urandom_range(99);
    gmask = (r < 40) ? 8'h00 : (r < 55) ? pmask : (r < 70) ? (8'($urandom) & pmask)
                                                           : 8'($urandom);
    kinds = ($urandom_range(99) < 85) ? $urandom_range(1, 3)
                                      : $urandom_range(4, rsv_pkg::MAX_SRC);
    for (int c = 0; c < rsv_pkg::MAX_SRC; c++) begin
      r = $urandom_range(99);
      style[c] = (r < 30) ? PAT_FILL : (r < 50) ? PAT_FLAT : PAT_NOISE;
      case ($urandom_range(2))
        0: fixed[c] = rsv_pkg::FILL_ZERO;
        1: fixed[c] = rsv_pkg::FILL_SPACE;
        default: fixed[c] = rsv_pkg::FILL_ONES;
      endcase
      if (style[c] != PAT_FILL) fixed[c] = 8'($urandom);
    end
    for (int s = 0; s < rsv_pkg::MAX_SRC; s++) cls[s] = $urandom_range(kinds - 1);
    bad_src = ($urandom_range(99) < 12) ? $urandom_range(rsv_pkg::MAX_SRC - 1) : -1;
    bad_pos = $urandom_range(len - 1);
    noisy = ($urandom_range(99) < 10);
    for (int t = 0; t < len; t++) begin
      for (int c = 0; c < rsv_pkg::MAX_SRC; c++)
        cval[c] = (style[c] == PAT_NOISE) ? 8'($urandom) : fixed[c];
      for (int s = 0; s < rsv_pkg::MAX_SRC; s++) begin
        v = noisy ? 8'($urandom) : cval[cls[s]];
        if (s == bad_src && t == bad_pos) v = v ^ 8'($urandom_range(1, 255));
        word[8 * s +: 8] = v;
      end
      if (t == 0) push_beat(pmask, gmask, word, len == 1);
      else push_beat(8'($urandom), 8'($urandom), word, t == len - 1);
    end
  endtask

  initial begin
    int len;
    int r;
    int phase_start;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    steady = 1'b0;
    hold_req = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed sectors, consensus off after reset
    push_beat(8'h00, 8'hFF, 64'h0, 1'b1);                        // nothing present
    push_beat(8'hFF, 8'hFF, {8{8'h5A}}, 1'b1);                   // all good, identical
    push_beat(8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);      // good fill copies
    push_beat(8'h07, 8'h07, 64'h0000_0000_0033_3333, 1'b0);      // majority, 2 of 3
    push_beat(8'h00, 8'h00, 64'h0000_0000_0044_3333, 1'b1);
    push_beat(8'h0F, 8'h0F, 64'h0000_0000_BBAA_BBAA, 1'b1);      // 2/2 split, tie
    push_beat(8'hF0, 8'h10, 64'h0123_4567_89AB_CDEF, 1'b1);      // sole good copy
    push_beat(8'h0F, 8'hF0, 64'h0000_0000_3131_2020, 1'b1);      // skip fill copies
    push_beat(8'h06, 8'h00, 64'h0000_0000_00FF_0000, 1'b1);      // all present are fill
    push_beat(8'h03, 8'h00, 64'h0000_0000_0000_2000, 1'b0);      // non-flat zeros
    push_beat(8'hFF, 8'hFF, 64'h0000_0000_0000_2001, 1'b0);
    push_beat(8'hFF, 8'hFF, 64'h0000_0000_0000_2000, 1'b1);
    push_beat(8'hFF, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    wait_drained();
    write_threshold(4'd2);
    push_beat(8'h07, 8'h00, 64'h0000_0000_0042_4141, 1'b1);      // consensus of two
    push_beat(8'h07, 8'h00, 64'h0, 1'b1);                        // agreed content is fill
    push_beat(8'h80, 8'h00, 64'h5500_0000_0000_0000, 1'b1);      // too few present

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_threshold(4'((ph < 12) ? thr_plan[ph] : $urandom_range(15)));
      steady = (ph == QUIET_PHASE);
      if (ph == PRESS_PHASE) hold_req = 1'b1;
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        r = $urandom_range(99);
        if (ph == PRESS_PHASE) len = 1;
        else if (r < 65) len = $urandom_range(1, 4);
        else if (r < 95) len = $urandom_range(5, 12);
        else len = $urandom_range(13, 40);
        send_sector(len);
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (verdicts_waiting != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d sectors in %0d beats under %0d threshold settings; %0d verdicts checked.",
             sectors_sent, beats_sent, settings_used, verdicts_checked);
    $display("Covered one-beat to long sectors, fill copies, a %0d-cycle output stall.",
             HOLD_LEN);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
